// ===== hdl/gap_pkg.sv =====
// ----------------------------------------------------------------------------
// gap_pkg
// Shared constants, codes and types of the grid auto-placement block.
// ----------------------------------------------------------------------------
package gap_pkg;

    // Grid capacity and the floor applied to the configured size.
    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 16;
    localparam int GRID_FLOOR = 10;

    // Widths of row indexes, row counts, column indexes and column counts.
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int ROWC_W = $clog2(MAX_ROWS) + 1;
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int COLC_W = $clog2(MAX_COLS) + 1;

    // Request and result field widths.
    localparam int ROW_SPAN_W  = 7;
    localparam int COL_SPAN_W  = 5;
    localparam int ROW_START_W = 6;
    localparam int COL_START_W = 4;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DENSE_FLOW   = 2'd0,
        REG_COL_COUNT    = 2'd1,
        REG_INITIAL_ROWS = 2'd2
    } gap_reg_t;

    // Request operations.
    typedef enum logic {
        OP_CLEAR = 1'b0,
        OP_PLACE = 1'b1
    } gap_op_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_UPDATE,
        ST_RESULT
    } gap_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clear;
        logic scan;
        logic start_upd;
        logic upd;
        logic commit;
        logic emit;
    } gap_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic miss;
        logic ovf;
        logic upd_done;
        logic out_free;
    } gap_stat_t;

endpackage

// ===== hdl/gap_in_if.sv =====
// ----------------------------------------------------------------------------
// gap_in_if
// Request channel: valid, ready and one placement or clear request.
// ----------------------------------------------------------------------------
interface gap_in_if;
    import gap_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [ROW_SPAN_W-1:0] row_span;
    logic [COL_SPAN_W-1:0] col_span;

    modport source (output valid, op, row_span, col_span, input ready);
    modport sink   (input valid, op, row_span, col_span, output ready);

endinterface

// ===== hdl/gap_out_if.sv =====
// ----------------------------------------------------------------------------
// gap_out_if
// Result channel: valid, ready and the placement given to one request.
// ----------------------------------------------------------------------------
interface gap_out_if;
    import gap_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [ROW_START_W-1:0] row_start;
    logic [COL_START_W-1:0] col_start;
    logic                   overflow;

    modport source (output valid, row_start, col_start, overflow, input ready);
    modport sink   (input valid, row_start, col_start, overflow, output ready);

endinterface

// ===== hdl/gap_ctrl.sv =====
// ----------------------------------------------------------------------------
// gap_ctrl
// Controller of the placement engine: sequences the search, the decision,
// the occupancy update and the hand-over of the result.
// ----------------------------------------------------------------------------
module gap_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_op,
    input  gap_pkg::gap_stat_t stat,
    output logic              in_ready,
    output gap_pkg::gap_cmd_t  cmd
);
    import gap_pkg::*;

    gap_state_t state_reg;
    gap_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (in_op == OP_PLACE))
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (stat.hit || stat.miss)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = stat.ovf ? ST_RESULT : ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (stat.upd_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands for the datapath.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_op == OP_PLACE)
                    begin
                        cmd.load = 1'b1;
                    end
                    else
                    begin
                        cmd.clear = 1'b1;
                    end
                end
            end
            ST_SEARCH:
            begin
                cmd.scan = 1'b1;
            end
            ST_DECIDE:
            begin
                if (!stat.ovf)
                begin
                    cmd.start_upd = 1'b1;
                    cmd.commit    = 1'b1;
                end
            end
            ST_UPDATE:
            begin
                cmd.upd = 1'b1;
            end
            ST_RESULT:
            begin
                cmd.emit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/gap_dpath.sv =====
// ----------------------------------------------------------------------------
// gap_dpath
// Datapath of the placement engine: configuration registers, occupancy
// memory, row-by-row first-fit search, read-modify-write update and the
// result register.
// ----------------------------------------------------------------------------
module gap_dpath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gap_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gap_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [gap_pkg::ROW_SPAN_W-1:0]    row_span,
    input  logic [gap_pkg::COL_SPAN_W-1:0]    col_span,
    input  gap_pkg::gap_cmd_t                 cmd,
    output gap_pkg::gap_stat_t                stat,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [gap_pkg::ROW_START_W-1:0]   row_start,
    output logic [gap_pkg::COL_START_W-1:0]   col_start,
    output logic                              overflow
);
    import gap_pkg::*;

    // Mask of the n lowest columns; n may exceed the grid width.
    function automatic logic [MAX_COLS-1:0] low_mask(input logic [COL_SPAN_W-1:0] n);
        logic [MAX_COLS-1:0] m;
        if (n >= COL_SPAN_W'(MAX_COLS))
        begin
            m = '1;
        end
        else
        begin
            m = (MAX_COLS'(1) << n) - MAX_COLS'(1);
        end
        return m;
    endfunction

    // Configuration registers.
    logic                  dense_reg;
    logic [COL_SPAN_W-1:0] col_count_reg;
    logic [ROWC_W-1:0]     init_rows_reg;

    // Grid state.
    logic [ROWC_W-1:0]     used_rows_reg;
    logic [ROWC_W-1:0]     cursor_row_reg;
    logic [COL_W-1:0]      cursor_col_reg;
    logic [MAX_ROWS-1:0]   row_valid_reg;
    logic [MAX_COLS-1:0]   occ_mem [MAX_ROWS];

    // Current request.
    logic [ROWC_W-1:0]     rs_reg;
    logic [COL_SPAN_W-1:0] cs_reg;
    logic [ROWC_W-1:0]     sr_reg;
    logic [COL_W-1:0]      sc_reg;
    logic                  skip_reg;

    // Row pipeline: read issue, read data, run counts.
    logic [ROWC_W-1:0]     rd_addr_reg;
    logic                  upd_mode_reg;
    logic                  v1_reg;
    logic [ROW_W-1:0]      tag1_reg;
    logic [MAX_COLS-1:0]   rd_data_reg;
    logic                  rd_vbit_reg;
    logic                  v2_reg;
    logic [ROW_W-1:0]      tag2_reg;
    logic [ROWC_W-1:0]     run_reg  [MAX_COLS];
    logic [ROWC_W-1:0]     run_next [MAX_COLS];

    // Placement found and result register.
    logic [ROWC_W-1:0]      res_row_reg;
    logic [COL_W-1:0]       res_col_reg;
    logic                   out_valid_reg;
    logic [ROW_START_W-1:0] out_row_reg;
    logic [COL_START_W-1:0] out_col_reg;
    logic                   out_ovf_reg;

    // Combinational signals.
    logic [COLC_W-1:0]     cols;
    logic [ROWC_W-1:0]     clear_rows;
    logic [ROWC_W-1:0]     rs_in;
    logic [COL_SPAN_W-1:0] cs_in;
    logic [ROWC_W-1:0]     sr_in;
    logic [COL_W-1:0]      sc_in;
    logic                  search_ok;
    logic [ROWC_W:0]       end_sum;
    logic [ROWC_W-1:0]     end_row;
    logic                  ovf;
    logic                  rd_issue;
    logic [MAX_COLS-1:0]   rd_eff;
    logic [MAX_COLS-1:0]   col_mask;
    logic [MAX_COLS-1:0]   wr_data;
    logic [MAX_COLS-1:0]   span;
    logic [MAX_COLS-1:0]   ok_vec;
    logic [MAX_COLS-1:0]   fit;
    logic                  cand_ok;
    logic [ROWC_W-1:0]     r_cand;
    logic [COL_W-1:0]      min_col;
    logic                  hit;
    logic [COL_W-1:0]      hit_col;
    logic                  last_row;
    logic                  miss;
    logic [COLC_W:0]       col_sum;

    // Columns in use and rows after a clear, both floored and limited.
    always_comb
    begin
        cols = (col_count_reg > COL_SPAN_W'(GRID_FLOOR)) ?
               COLC_W'(col_count_reg) : COLC_W'(GRID_FLOOR);
        if (cols > COLC_W'(MAX_COLS))
        begin
            cols = COLC_W'(MAX_COLS);
        end
        clear_rows = (init_rows_reg > ROWC_W'(GRID_FLOOR)) ?
                     init_rows_reg : ROWC_W'(GRID_FLOOR);
        if (clear_rows > ROWC_W'(MAX_ROWS))
        begin
            clear_rows = ROWC_W'(MAX_ROWS);
        end
    end

    // Incoming request: zero spans count as one, start at origin or cursor.
    always_comb
    begin
        rs_in     = (row_span == '0) ? ROWC_W'(1) : ROWC_W'(row_span);
        cs_in     = (col_span == '0) ? COL_SPAN_W'(1) : col_span;
        sr_in     = dense_reg ? '0 : cursor_row_reg;
        sc_in     = dense_reg ? '0 : cursor_col_reg;
        search_ok = (COLC_W'(cs_in) <= cols) &&
                    (({1'b0, sr_in} + {1'b0, rs_in}) <= {1'b0, used_rows_reg});
    end

    // End of the chosen rows, and whether they pass the row capacity.
    assign end_sum = {1'b0, res_row_reg} + {1'b0, rs_reg};
    assign end_row = end_sum[ROWC_W-1:0];
    assign ovf     = end_sum > (ROWC_W + 1)'(MAX_ROWS);

    // A row read is issued while the search or the update has rows left.
    assign rd_issue = (cmd.scan && !skip_reg && (rd_addr_reg < used_rows_reg)) ||
                      (cmd.upd && (rd_addr_reg < end_row));

    // A row never written since the last clear reads as free.
    assign rd_eff = rd_vbit_reg ? rd_data_reg : '0;

    // Update data: the item's columns, clipped to the columns in use.
    assign col_mask = (cols >= COLC_W'(MAX_COLS)) ? '1 :
                      ((MAX_COLS'(1) << cols) - MAX_COLS'(1));
    assign wr_data  = rd_eff | ((low_mask(cs_reg) << res_col_reg) & col_mask);

    // Count of free rows in each column, from the search start downwards.
    always_comb
    begin
        for (int c = 0; c < MAX_COLS; c++)
        begin
            if (rd_eff[c])
            begin
                run_next[c] = '0;
            end
            else if (run_reg[c] == '1)
            begin
                run_next[c] = run_reg[c];
            end
            else
            begin
                run_next[c] = run_reg[c] + ROWC_W'(1);
            end
        end
    end

    // Window test on the row whose runs are current: the candidate start
    // row lies row_span - 1 rows above it, and the lowest fitting column wins.
    always_comb
    begin
        span     = low_mask(cs_reg);
        cand_ok  = v2_reg && !upd_mode_reg && !skip_reg &&
                   (({2'b0, tag2_reg} + (ROWC_W + 1)'(1)) >=
                    ({1'b0, sr_reg} + {1'b0, rs_reg}));
        r_cand   = ROWC_W'({1'b0, tag2_reg} + ROWC_W'(1) - rs_reg);
        min_col  = (r_cand == sr_reg) ? sc_reg : '0;
        for (int c = 0; c < MAX_COLS; c++)
        begin
            ok_vec[c] = run_reg[c] >= rs_reg;
        end
        for (int c = 0; c < MAX_COLS; c++)
        begin
            fit[c] = ((COLC_W + 1)'(c) + (COLC_W + 1)'(cs_reg) <= (COLC_W + 1)'(cols)) &&
                     (COL_W'(c) >= min_col) &&
                     (((~ok_vec >> c) & span) == '0);
        end
        hit_col = '0;
        for (int c = MAX_COLS - 1; c >= 0; c--)
        begin
            if (fit[c])
            begin
                hit_col = COL_W'(c);
            end
        end
        hit      = cand_ok && (|fit);
        last_row = ({1'b0, tag2_reg} + ROWC_W'(1)) == used_rows_reg;
        miss     = skip_reg || (v2_reg && !upd_mode_reg && last_row && !hit);
    end

    // Cursor advance past the placed item.
    assign col_sum = (COLC_W + 1)'(res_col_reg) + (COLC_W + 1)'(cs_reg);

    // Status for the controller.
    always_comb
    begin
        stat.hit      = hit;
        stat.miss     = miss;
        stat.ovf      = ovf;
        stat.upd_done = (rd_addr_reg == end_row) && !v1_reg;
        stat.out_free = !out_valid_reg || out_ready;
    end

    // Control state: configuration, grid state, pipeline valids, result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dense_reg      <= 1'b0;
            col_count_reg  <= COL_SPAN_W'(GRID_FLOOR);
            init_rows_reg  <= ROWC_W'(GRID_FLOOR);
            used_rows_reg  <= ROWC_W'(GRID_FLOOR);
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            row_valid_reg  <= '0;
            skip_reg       <= 1'b0;
            rd_addr_reg    <= '0;
            upd_mode_reg   <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // Configuration writes; unknown indexes are ignored.
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DENSE_FLOW:   dense_reg     <= cfg_data[0];
                    REG_COL_COUNT:    col_count_reg <= cfg_data[COL_SPAN_W-1:0];
                    REG_INITIAL_ROWS: init_rows_reg <= cfg_data[ROWC_W-1:0];
                    default:          ;
                endcase
            end

            // Clear empties the grid at once through the row valid bits.
            if (cmd.clear)
            begin
                used_rows_reg  <= clear_rows;
                cursor_row_reg <= '0;
                cursor_col_reg <= '0;
                row_valid_reg  <= '0;
            end

            // New placement request.
            if (cmd.load)
            begin
                skip_reg     <= !search_ok;
                rd_addr_reg  <= sr_in;
                upd_mode_reg <= 1'b0;
            end
            else if (cmd.start_upd)
            begin
                rd_addr_reg  <= res_row_reg;
                upd_mode_reg <= 1'b1;
            end
            else if (rd_issue)
            begin
                rd_addr_reg <= rd_addr_reg + ROWC_W'(1);
            end

            // Pipeline valids, flushed when a new pass starts.
            if (cmd.load || cmd.start_upd)
            begin
                v1_reg <= 1'b0;
                v2_reg <= 1'b0;
            end
            else
            begin
                v1_reg <= rd_issue;
                v2_reg <= v1_reg && !upd_mode_reg;
            end

            // Rows written by the update become valid.
            if (v1_reg && upd_mode_reg)
            begin
                row_valid_reg[tag1_reg] <= 1'b1;
            end

            // Grid growth and cursor move for a placement that fits.
            if (cmd.commit)
            begin
                if (end_row > used_rows_reg)
                begin
                    used_rows_reg <= end_row;
                end
                if (col_sum >= (COLC_W + 1)'(cols))
                begin
                    cursor_col_reg <= '0;
                    cursor_row_reg <= res_row_reg + ROWC_W'(1);
                end
                else
                begin
                    cursor_col_reg <= col_sum[COL_W-1:0];
                    cursor_row_reg <= res_row_reg;
                end
            end

            // Result valid.
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers and the occupancy memory.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= occ_mem[rd_addr_reg[ROW_W-1:0]];
        rd_vbit_reg <= row_valid_reg[rd_addr_reg[ROW_W-1:0]];

        if (v1_reg && upd_mode_reg)
        begin
            occ_mem[tag1_reg] <= wr_data;
        end

        if (cmd.load)
        begin
            rs_reg <= rs_in;
            cs_reg <= cs_in;
            sr_reg <= sr_in;
            sc_reg <= sc_in;
            for (int c = 0; c < MAX_COLS; c++)
            begin
                run_reg[c] <= '0;
            end
        end
        else if (v1_reg && !upd_mode_reg)
        begin
            for (int c = 0; c < MAX_COLS; c++)
            begin
                run_reg[c] <= run_next[c];
            end
        end

        if (rd_issue)
        begin
            tag1_reg <= rd_addr_reg[ROW_W-1:0];
        end
        if (v1_reg)
        begin
            tag2_reg <= tag1_reg;
        end

        // Placement found, or the growth position below the used rows.
        if (cmd.scan && hit)
        begin
            res_row_reg <= r_cand;
            res_col_reg <= hit_col;
        end
        else if (cmd.scan && miss)
        begin
            res_row_reg <= used_rows_reg;
            res_col_reg <= '0;
        end

        if (cmd.emit)
        begin
            out_row_reg <= ovf ? '0 : res_row_reg[ROW_START_W-1:0];
            out_col_reg <= ovf ? '0 : res_col_reg;
            out_ovf_reg <= ovf;
        end
    end

    assign out_valid = out_valid_reg;
    assign row_start = out_row_reg;
    assign col_start = out_col_reg;
    assign overflow  = out_ovf_reg;

endmodule

// ===== hdl/grid_auto_placement_top.sv =====
// ----------------------------------------------------------------------------
// grid_auto_placement_top
// First-fit placement of rectangles into a grid occupancy bitmap.
// ----------------------------------------------------------------------------
// One request is handled at a time. A clear gives no result. A placement
// reads the occupancy memory one row word per cycle, once for each row
// scanned in the first-fit search and once for each row marked in the
// read-modify-write update. The search ends early on the first fitting
// position. The result sits in an output register, so the next request is
// taken once the previous result has been handed over to that register.
// After reset and after a clear the grid is empty at once; there is no
// clearing pass.
module grid_auto_placement_top (
    input  logic                           clk,
    input  logic                           rst_n,
    gap_in_if.sink                         in_ch,
    gap_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [gap_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gap_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gap_pkg::*;

    gap_cmd_t  cmd;
    gap_stat_t stat;
    logic      in_ready;

    // Controller.
    gap_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_op    (in_ch.op),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // Datapath.
    gap_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .row_span  (in_ch.row_span),
        .col_span  (in_ch.col_span),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .row_start (out_ch.row_start),
        .col_start (out_ch.col_start),
        .overflow  (out_ch.overflow)
    );

    assign in_ch.ready = in_ready;

endmodule
